FILE: src/bcm_pkg.sv
// shared types, constants and scaling functions for the battery charge monitor
// no dependencies

package bcm_pkg;

    localparam int unsigned ACC_BITS   = 16;
    localparam int unsigned LEVEL_BITS = 12;
    localparam int unsigned SCALE_BITS = 15;
    localparam int unsigned TEMP_BITS  = 13;

    localparam logic [LEVEL_BITS-1:0] CHARGE_END_RESET   = 12'd1370;
    localparam logic [LEVEL_BITS-1:0] CHARGE_START_RESET = 12'd1340;
    localparam logic [LEVEL_BITS-1:0] BATTERY_OK_RESET   = 12'd1130;
    localparam logic [LEVEL_BITS-1:0] BATTERY_LOW_RESET  = 12'd1080;

    // ceil(2^28/79), ceil(2^28/77), ceil(2^26/51)
    localparam logic [21:0] BAT_RECIP    = 22'd3397918;
    localparam logic [21:0] SUP_RECIP    = 22'd3486175;
    localparam logic [20:0] TEMP_RECIP   = 21'd1315861;
    localparam logic [16:0] TEMP_OFFSET  = 17'd655;

    typedef enum logic [1:0] {
        CFG_CHARGE_END   = 2'd0,
        CFG_CHARGE_START = 2'd1,
        CFG_BATTERY_OK   = 2'd2,
        CFG_BATTERY_LOW  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] charge_end;
        logic [LEVEL_BITS-1:0] charge_start;
        logic [LEVEL_BITS-1:0] battery_ok;
        logic [LEVEL_BITS-1:0] battery_low;
    } t_cfg;

    typedef struct packed {
        logic charge;
        logic low;
    } t_flags;

    // acc*32/79 as acc*m >> 23
    function automatic logic [SCALE_BITS-1:0] scale_battery(input logic [ACC_BITS-1:0] acc);
        logic [37:0] p;
        p = 38'(acc) * 38'(BAT_RECIP);
        return p[37:23];
    endfunction

    // acc*32/77 as acc*m >> 23
    function automatic logic [SCALE_BITS-1:0] scale_supply(input logic [ACC_BITS-1:0] acc);
        logic [37:0] p;
        p = 38'(acc) * 38'(SUP_RECIP);
        return p[37:23];
    endfunction

    // (acc-655)*16/51, truncated toward zero, via magnitude
    function automatic logic signed [15:0] scale_temp(input logic [ACC_BITS-1:0] acc);
        logic [16:0]        d;
        logic [15:0]        mag;
        logic [36:0]        p;
        logic signed [15:0] qs;
        d   = {1'b0, acc} - TEMP_OFFSET;
        mag = d[16] ? 16'(-d) : d[15:0];
        p   = 37'(mag) * 37'(TEMP_RECIP);
        qs  = signed'({1'b0, p[36:22]});
        return d[16] ? -qs : qs;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [SCALE_BITS-1:0] v);
        return (v > SCALE_BITS'(4095)) ? 12'hFFF : v[LEVEL_BITS-1:0];
    endfunction

    function automatic logic signed [TEMP_BITS-1:0] sat_temp(input logic signed [15:0] t);
        logic signed [TEMP_BITS-1:0] r;
        if (t > 16'sd4095) begin
            r = 13'sd4095;
        end else if (t < -16'sd4096) begin
            r = -13'sd4096;
        end else begin
            r = t[TEMP_BITS-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/battery_charge_monitor.sv
// battery charge monitor top level: input register, filters, scaling, result register
// depends on bcm_pkg, bcm_cfg, bcm_channel, bcm_decide
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one word of three raw samples
//   and a decision request; output channel (o_out_valid / i_out_ready) carries
//   both flags and the three scaled levels after that word's filter update
//   a word is held in the input register, then its result in the result register
//   throughput: one word per cycle while the receiver takes results; the filter update, one constant-reciprocal
//   multiply per channel and the saturation sit between the input register and
//   the result register, and the decision compares registered levels only
//   when the receiver stalls, the result register holds and the input register
//   still takes a word if it is empty; o_in_ready drops only when both are full
//   reset clears the accumulators, flags, stored levels and both valid bits and
//   loads the default thresholds; the plain write port updates a threshold in
//   the cycle its write enable is high, with no wait

module battery_charge_monitor #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [11:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SAMPLE_BITS-1:0]  i_battery_sample,
    input  logic [SAMPLE_BITS-1:0]  i_supply_sample,
    input  logic [SAMPLE_BITS-1:0]  i_temp_sample,
    input  logic                    i_run_decision,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_charge_enable,
    output logic                    o_low_battery,
    output logic [11:0]             o_battery_level,
    output logic [11:0]             o_supply_level,
    output logic signed [12:0]      o_temp_level
);

    bcm_pkg::t_cfg                  w_cfg;
    bcm_pkg::t_flags                w_flags;
    logic                           w_advance;
    logic                           w_fire;
    logic [bcm_pkg::ACC_BITS-1:0]   w_bat_acc;
    logic [bcm_pkg::ACC_BITS-1:0]   w_sup_acc;
    logic [bcm_pkg::ACC_BITS-1:0]   w_temp_acc;
    logic [bcm_pkg::SCALE_BITS-1:0] w_bat_scaled;
    logic [bcm_pkg::SCALE_BITS-1:0] w_sup_scaled;

    logic                           r_in_valid;
    logic [SAMPLE_BITS-1:0]         r_bat_sample;
    logic [SAMPLE_BITS-1:0]         r_sup_sample;
    logic [SAMPLE_BITS-1:0]         r_temp_sample;
    logic                           r_run;

    logic                           r_out_valid;
    logic                           r_charge;
    logic                           r_low;
    logic [11:0]                    r_bat_level;
    logic [11:0]                    r_sup_level;
    logic signed [12:0]             r_temp_level;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    bcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_bat_sample  <= i_battery_sample;
            r_sup_sample  <= i_supply_sample;
            r_temp_sample <= i_temp_sample;
            r_run         <= i_run_decision;
        end
    end

    bcm_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_bat_ch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_fire),
        .i_sample   (r_bat_sample),
        .o_acc_next (w_bat_acc)
    );

    bcm_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_sup_ch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_fire),
        .i_sample   (r_sup_sample),
        .o_acc_next (w_sup_acc)
    );

    bcm_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_temp_ch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_fire),
        .i_sample   (r_temp_sample),
        .o_acc_next (w_temp_acc)
    );

    assign w_bat_scaled = bcm_pkg::scale_battery(w_bat_acc);
    assign w_sup_scaled = bcm_pkg::scale_supply(w_sup_acc);

    bcm_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_fire),
        .i_run       (r_run),
        .i_cfg       (w_cfg),
        .i_bat_level (w_bat_scaled),
        .i_sup_level (w_sup_scaled),
        .o_flags     (w_flags)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_charge     <= w_flags.charge;
            r_low        <= w_flags.low;
            r_bat_level  <= bcm_pkg::sat_level(w_bat_scaled);
            r_sup_level  <= bcm_pkg::sat_level(w_sup_scaled);
            r_temp_level <= bcm_pkg::sat_temp(bcm_pkg::scale_temp(w_temp_acc));
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_charge_enable = r_charge;
    assign o_low_battery   = r_low;
    assign o_battery_level = r_bat_level;
    assign o_supply_level  = r_sup_level;
    assign o_temp_level    = r_temp_level;

endmodule

FILE: src/bcm_cfg.sv
// threshold register file for the battery charge monitor
// depends on bcm_pkg

module bcm_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [11:0]          i_cfg_data,
    output bcm_pkg::t_cfg        o_cfg
);

    bcm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_end   <= bcm_pkg::CHARGE_END_RESET;
            r_cfg.charge_start <= bcm_pkg::CHARGE_START_RESET;
            r_cfg.battery_ok   <= bcm_pkg::BATTERY_OK_RESET;
            r_cfg.battery_low  <= bcm_pkg::BATTERY_LOW_RESET;
        end else if (i_cfg_we) begin
            unique case (bcm_pkg::t_cfg_idx'(i_cfg_index))
                bcm_pkg::CFG_CHARGE_END:   r_cfg.charge_end   <= i_cfg_data;
                bcm_pkg::CFG_CHARGE_START: r_cfg.charge_start <= i_cfg_data;
                bcm_pkg::CFG_BATTERY_OK:   r_cfg.battery_ok   <= i_cfg_data;
                bcm_pkg::CFG_BATTERY_LOW:  r_cfg.battery_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/bcm_channel.sv
// one filtered converter channel: 16-bit accumulator, acc += raw - (acc >> 3)
// depends on bcm_pkg

module bcm_channel #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_update,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    output logic [bcm_pkg::ACC_BITS-1:0]  o_acc_next
);

    logic [bcm_pkg::ACC_BITS-1:0] r_acc;
    logic [bcm_pkg::ACC_BITS-1:0] n_acc;

    assign n_acc = r_acc + bcm_pkg::ACC_BITS'(i_sample) - (r_acc >> 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_update) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc_next = n_acc;

endmodule

FILE: src/bcm_decide.sv
// charger and low-battery hysteresis on the levels of the previous word
// depends on bcm_pkg

module bcm_decide (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_update,
    input  logic                            i_run,
    input  bcm_pkg::t_cfg                   i_cfg,
    input  logic [bcm_pkg::SCALE_BITS-1:0]  i_bat_level,
    input  logic [bcm_pkg::SCALE_BITS-1:0]  i_sup_level,
    output bcm_pkg::t_flags                 o_flags
);

    logic [bcm_pkg::SCALE_BITS-1:0] r_bat_level;
    logic [bcm_pkg::SCALE_BITS-1:0] r_sup_level;
    bcm_pkg::t_flags                r_flags;
    bcm_pkg::t_flags                n_flags;

    always_comb begin
        n_flags = r_flags;
        if (i_run) begin
            if (r_sup_level > r_bat_level) begin
                if (r_bat_level >= bcm_pkg::SCALE_BITS'(i_cfg.charge_end)) begin
                    n_flags.charge = 1'b0;
                end
                if (r_bat_level < bcm_pkg::SCALE_BITS'(i_cfg.charge_start)) begin
                    n_flags.charge = 1'b1;
                end
            end else begin
                n_flags.charge = 1'b0;
            end
            if (r_bat_level < bcm_pkg::SCALE_BITS'(i_cfg.battery_low)) begin
                n_flags.low = 1'b1;
            end
            if (n_flags.low && r_bat_level > bcm_pkg::SCALE_BITS'(i_cfg.battery_ok)) begin
                n_flags.low = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bat_level <= '0;
            r_sup_level <= '0;
            r_flags     <= '0;
        end else if (i_update) begin
            r_bat_level <= i_bat_level;
            r_sup_level <= i_sup_level;
            r_flags     <= n_flags;
        end
    end

    assign o_flags = n_flags;

endmodule

FILE: src/bcm_checker.sv
// port-level checks for the battery charge monitor, bound to the top level
// depends on battery_charge_monitor

module bcm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               o_charge_enable,
    input  logic               o_low_battery,
    input  logic [11:0]        o_battery_level,
    input  logic signed [12:0] o_temp_level
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_battery_level)
            && $stable(o_charge_enable) && $stable(o_low_battery))
        else $error("stalled result changed");

    // input side blocks only when the result register is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    // temperature level stays at or above -256
    a_temp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_temp_level >= -13'sd256)
        else $error("temperature level below range");

endmodule

bind battery_charge_monitor bcm_checker u_bcm_checker (.*);
